// ----- sv/pidd_pkg.sv -----
`default_nettype none

package pidd_pkg;

	// APB register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_BASE_SPEED = 3'd3,
		REG_CORR_MIN   = 3'd4,
		REG_CORR_MAX   = 3'd5
	} cfg_reg_t;

	localparam int unsigned PADDR_W = 5;

	// Q4.12 one and the integral clamp
	localparam logic signed [16:0] ERR_ONE     = 17'sd4096;
	localparam logic signed [16:0] ERR_ONE_NEG = -17'sd4096;

	// correction = round(t / (100 * 4096)), ties away from zero
	localparam logic [30:0] ROUND_HALF  = 31'd204800;
	localparam int unsigned FRAC_SHIFT  = 12;
	// floor(x / 100) = (x * 5243) >> 19, exact for x <= 25600
	localparam logic [14:0] QUOT_SAT    = 15'd25600;
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [6:0] FIXED_DUTY = 7'd50;
	localparam logic [6:0] DUTY_MAX   = 7'd100;

	localparam logic [6:0]        BASE_SPEED_RST = 7'd50;
	localparam logic signed [7:0] CORR_MIN_RST   = -8'sd100;
	localparam logic signed [7:0] CORR_MAX_RST   = 8'sd100;

endpackage

`default_nettype wire

// ----- sv/pid_differential_drive_top.sv -----
`default_nettype none

// Differential-drive steering controller. Each input word carries a Q4.12
// steering error, an unsigned Q2.8 speed factor and a fixed-speed flag;
// each output word carries left and right forward duties (0..100) and the
// clamped PID correction. The integral sum (clamped to +/-1.0) and the
// previous error are updated as the word is accepted, so words may arrive
// in every cycle: throughput is one word per clock unless the output
// stalls. The accept edge loads the input/state register, then the gain
// multipliers, sum and rounding, reciprocal multiply and output clamp each
// feed a register. The stages move together with bubble collapse; in_ready
// drops only when every stage and the output register are full and the
// output is not taken. A fixed-speed word yields 50/50 with a zero
// correction and leaves the PID state untouched. Gains, base speed and
// correction limits are written over APB (byte address 4*index); the user
// must write them only while the pipe is empty; the block does not check.
module pid_differential_drive_top
	import pidd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  steer_error,
	input  wire logic [9:0]          speed_factor,
	input  wire logic                fixed_speed,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [6:0]               left_duty,
	output logic [6:0]               right_duty,
	output logic signed [7:0]        steer_correction
);

	// ---------------- configuration registers ----------------
	logic [12:0]       gain_p_q;
	logic [9:0]        gain_i_q;
	logic [9:0]        gain_d_q;
	logic [6:0]        base_speed_q;
	logic signed [7:0] corr_min_q;
	logic signed [7:0] corr_max_q;

	logic     cfg_wr;
	cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			base_speed_q <= BASE_SPEED_RST;
			corr_min_q   <= CORR_MIN_RST;
			corr_max_q   <= CORR_MAX_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_GAIN_P:     gain_p_q     <= pwdata[12:0];
				REG_GAIN_I:     gain_i_q     <= pwdata[9:0];
				REG_GAIN_D:     gain_d_q     <= pwdata[9:0];
				REG_BASE_SPEED: base_speed_q <= pwdata[6:0];
				REG_CORR_MIN:   corr_min_q   <= pwdata[7:0];
				REG_CORR_MAX:   corr_max_q   <= pwdata[7:0];
				default: ;  // unmapped indexes ignored
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_sel)
			REG_GAIN_P:     prdata = {19'd0, gain_p_q};
			REG_GAIN_I:     prdata = {22'd0, gain_i_q};
			REG_GAIN_D:     prdata = {22'd0, gain_d_q};
			REG_BASE_SPEED: prdata = {25'd0, base_speed_q};
			REG_CORR_MIN:   prdata = {24'd0, corr_min_q};
			REG_CORR_MAX:   prdata = {24'd0, corr_max_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	// a stage loads when it is empty or its contents move on
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_out, en_s4, en_s3, en_s2, en_s1;
	logic in_acc;

	assign en_out   = !out_valid || out_ready;
	assign en_s4    = !v_s4 || en_out;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1)  v_s1      <= in_valid;
			if (en_s2)  v_s2      <= v_s1;
			if (en_s3)  v_s3      <= v_s2;
			if (en_s4)  v_s4      <= v_s3;
			if (en_out) out_valid <= v_s4;
		end
	end

	// ---------------- stage 1: PID state update at accept ----------------
	logic signed [13:0] error_sum_q;
	logic signed [15:0] last_error_q;
	logic signed [16:0] sum_raw;
	logic signed [13:0] sum_nx;
	logic signed [16:0] diff_nx;

	assign sum_raw = {{3{error_sum_q[13]}}, error_sum_q} + {steer_error[15], steer_error};
	assign diff_nx = {steer_error[15], steer_error} - {last_error_q[15], last_error_q};

	// integral clamp to +/-1.0
	always_comb begin
		if (sum_raw > ERR_ONE)
			sum_nx = ERR_ONE[13:0];
		else if (sum_raw < ERR_ONE_NEG)
			sum_nx = ERR_ONE_NEG[13:0];
		else
			sum_nx = sum_raw[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (in_acc && !fixed_speed) begin
			error_sum_q  <= sum_nx;
			last_error_q <= steer_error;
		end
	end

	logic signed [15:0] err_s1;
	logic signed [13:0] sum_s1;
	logic signed [16:0] diff_s1;
	logic [9:0]         factor_s1;
	logic               fixed_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_s1    <= steer_error;
			sum_s1    <= sum_nx;
			diff_s1   <= diff_nx;
			factor_s1 <= speed_factor;
			fixed_s1  <= fixed_speed;
		end
	end

	// ---------------- stage 2: gain products, base duty ----------------
	logic signed [29:0] prod_p;
	logic signed [24:0] prod_i;
	logic signed [27:0] prod_d;
	logic [16:0]        base_full;

	assign prod_p    = $signed({1'b0, gain_p_q}) * err_s1;
	assign prod_i    = $signed({1'b0, gain_i_q}) * sum_s1;
	assign prod_d    = $signed({1'b0, gain_d_q}) * diff_s1;
	assign base_full = base_speed_q * factor_s1;

	logic signed [29:0] pp_s2;
	logic signed [24:0] pi_s2;
	logic signed [27:0] pd_s2;
	logic [8:0]         base_s2;
	logic               fixed_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			pp_s2    <= prod_p;
			pi_s2    <= prod_i;
			pd_s2    <= prod_d;
			base_s2  <= base_full[16:8];  // floor(base * factor / 256)
			fixed_s2 <= fixed_s1;
		end
	end

	// ---------------- stage 3: sum, magnitude, round, scale ----------------
	logic signed [31:0] t_sum;
	logic [31:0]        t_mag;
	logic [30:0]        t_rnd;
	logic [18:0]        quot_in;
	logic [14:0]        quot_sat;

	assign t_sum = {{2{pp_s2[29]}}, pp_s2} + {{7{pi_s2[24]}}, pi_s2}
	             + {{4{pd_s2[27]}}, pd_s2};
	assign t_mag = t_sum[31] ? 32'(-t_sum) : 32'(t_sum);
	// |t| < 2^30, so the rounded sum fits 31 bits
	assign t_rnd   = t_mag[30:0] + ROUND_HALF;
	assign quot_in = t_rnd[30:FRAC_SHIFT];
	// beyond 256 the output clamp decides anyway
	assign quot_sat = (quot_in >= 19'(QUOT_SAT)) ? QUOT_SAT : quot_in[14:0];

	logic [14:0] quot_s3;
	logic        neg_s3;
	logic [8:0]  base_s3;
	logic        fixed_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			quot_s3  <= quot_sat;
			neg_s3   <= t_sum[31];
			base_s3  <= base_s2;
			fixed_s3 <= fixed_s2;
		end
	end

	// ---------------- stage 4: divide by 100 via reciprocal ----------------
	logic [27:0] recip_s4;
	logic        neg_s4;
	logic [8:0]  base_s4;
	logic        fixed_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			recip_s4 <= quot_s3 * RECIP_100;
			neg_s4   <= neg_s3;
			base_s4  <= base_s3;
			fixed_s4 <= fixed_s3;
		end
	end

	// ---------------- output stage: clamp, mix, saturate ----------------
	logic [8:0]         q_mag;
	logic signed [9:0]  q_sgn;
	logic signed [9:0]  cmin_ext, cmax_ext;
	logic signed [7:0]  corr;
	logic signed [10:0] left_raw, right_raw;
	logic [6:0]         left_sat, right_sat;

	assign q_mag    = recip_s4[27:RECIP_SHIFT];
	assign q_sgn    = neg_s4 ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign cmin_ext = {{2{corr_min_q[7]}}, corr_min_q};
	assign cmax_ext = {{2{corr_max_q[7]}}, corr_max_q};

	// upper limit checked first, matters when limits are inverted
	always_comb begin
		if (q_sgn > cmax_ext)
			corr = corr_max_q;
		else if (q_sgn < cmin_ext)
			corr = corr_min_q;
		else
			corr = q_sgn[7:0];
	end

	assign left_raw  = $signed({2'b00, base_s4}) + {{3{corr[7]}}, corr};
	assign right_raw = $signed({2'b00, base_s4}) - {{3{corr[7]}}, corr};

	always_comb begin
		if (left_raw[10])
			left_sat = '0;
		else if (left_raw > $signed({4'd0, DUTY_MAX}))
			left_sat = DUTY_MAX;
		else
			left_sat = left_raw[6:0];

		if (right_raw[10])
			right_sat = '0;
		else if (right_raw > $signed({4'd0, DUTY_MAX}))
			right_sat = DUTY_MAX;
		else
			right_sat = right_raw[6:0];
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s4) begin
			if (fixed_s4) begin
				left_duty        <= FIXED_DUTY;
				right_duty       <= FIXED_DUTY;
				steer_correction <= '0;
			end else begin
				left_duty        <= left_sat;
				right_duty       <= right_sat;
				steer_correction <= corr;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/pidd_checker.sv -----
`default_nettype none

module pidd_checker
	import pidd_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [6:0]          left_duty,
	input wire logic [6:0]          right_duty,
	input wire logic signed [7:0]   steer_correction
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_duty)
			&& $stable(right_duty) && $stable(steer_correction))
		else $error("output word changed while stalled");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_duty <= DUTY_MAX && right_duty <= DUTY_MAX)
		else $error("duty above max");

	// unsaturated duties differ by twice the correction
	a_duty_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_duty != 7'd0 && right_duty != 7'd0
			&& left_duty != DUTY_MAX && right_duty != DUTY_MAX
		|-> ($signed({2'b00, left_duty}) - $signed({2'b00, right_duty}))
			== $signed({steer_correction[7], steer_correction}) * 9'sd2)
		else $error("left/right split does not match correction");

	a_corr_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && steer_correction > 8'sd0 |-> left_duty >= right_duty)
		else $error("positive correction but left below right");

	// a full, stalled output register must not leave the input open forever
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && $past(out_valid && !out_ready)
			&& $past(in_valid && in_ready, 1) && $past(in_valid && in_ready, 2)
			&& $past(in_valid && in_ready, 3) && $past(in_valid && in_ready, 4)
		|-> !in_ready)
		else $error("input accepted with pipeline full");

endmodule

bind pid_differential_drive_top pidd_checker u_pidd_checker (.*);

`default_nettype wire
